// File: src/psah_pkg.sv
// ----------------------------------------------------------------------------
// Pack sample averager package
// Shared types, command codes and constants for the averager block.
// ----------------------------------------------------------------------------
`default_nettype none
package psah_pkg;
   localparam int PACKS_DEFAULT = 8;
   localparam int HISTORY_DEPTH_DEFAULT = 32;
   localparam logic [15:0] PERIOD_RESET = 16'd60;
   localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

   typedef enum logic [1:0] {
      CMD_RECORD = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   localparam logic KIND_ARCHIVE = 1'b0;
   localparam logic KIND_HISTORY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_STATE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_EMIT_AVG,
      ST_HIST_RD,
      ST_HIST_EMIT
   } state_type;

   // One result transaction: kind, pack, stamp, volt, amps, charge, temp, last.
   typedef struct packed {
      logic        last;
      logic [7:0]  temp;
      logic [6:0]  charge;
      logic [23:0] amps;
      logic [15:0] volt;
      logic [31:0] stamp;
      logic [2:0]  pack;
      logic        kind;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [16:0] divisor;
      logic [32:0] sum_volt;
      logic [40:0] sum_current;
      logic [23:0] sum_charge;
      logic [24:0] sum_temp;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] volt;
      logic [23:0] amps;
      logic [6:0]  charge;
      logic [7:0]  temp;
   } div_rsp_type;
endpackage
`default_nettype wire

// File: src/psah_divider.sv
// ----------------------------------------------------------------------------
// Averager divider
// Restoring divider that divides four sums by one count, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module psah_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire psah_pkg::div_req_type req,
   output psah_pkg::div_rsp_type     rsp
);
   localparam int W = 41;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0] qv_ff, qa_ff, qc_ff, qt_ff;
   logic [16:0]  rv_ff, rc_ff, rt_ff, ra_ff;
   logic [16:0]  den_ff;
   logic         neg_a_ff, neg_t_ff, busy_ff, done_ff;
   logic [CW-1:0] cnt_ff;

   logic [17:0] tv, ta, tc, tt;
   assign tv = {rv_ff, qv_ff[W-1]};
   assign ta = {ra_ff, qa_ff[W-1]};
   assign tc = {rc_ff, qc_ff[W-1]};
   assign tt = {rt_ff, qt_ff[W-1]};

   logic [40:0] abs_a;
   logic [24:0] abs_t;
   assign abs_a = req.sum_current[40] ? 41'(-req.sum_current) : req.sum_current;
   assign abs_t = req.sum_temp[24] ? 25'(-req.sum_temp) : req.sum_temp;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         den_ff   <= req.divisor;
         qv_ff    <= W'(req.sum_volt);
         qa_ff    <= abs_a;
         qc_ff    <= W'(req.sum_charge);
         qt_ff    <= W'(abs_t);
         neg_a_ff <= req.sum_current[40];
         neg_t_ff <= req.sum_temp[24];
         rv_ff <= '0; ra_ff <= '0; rc_ff <= '0; rt_ff <= '0;
      end else if (busy_ff) begin
         if (tv >= {1'b0, den_ff}) begin
            rv_ff <= 17'(tv - {1'b0, den_ff}); qv_ff <= {qv_ff[W-2:0], 1'b1};
         end else begin
            rv_ff <= tv[16:0]; qv_ff <= {qv_ff[W-2:0], 1'b0};
         end
         if (ta >= {1'b0, den_ff}) begin
            ra_ff <= 17'(ta - {1'b0, den_ff}); qa_ff <= {qa_ff[W-2:0], 1'b1};
         end else begin
            ra_ff <= ta[16:0]; qa_ff <= {qa_ff[W-2:0], 1'b0};
         end
         if (tc >= {1'b0, den_ff}) begin
            rc_ff <= 17'(tc - {1'b0, den_ff}); qc_ff <= {qc_ff[W-2:0], 1'b1};
         end else begin
            rc_ff <= tc[16:0]; qc_ff <= {qc_ff[W-2:0], 1'b0};
         end
         if (tt >= {1'b0, den_ff}) begin
            rt_ff <= 17'(tt - {1'b0, den_ff}); qt_ff <= {qt_ff[W-2:0], 1'b1};
         end else begin
            rt_ff <= tt[16:0]; qt_ff <= {qt_ff[W-2:0], 1'b0};
         end
      end
   end

   logic [23:0] qa_low;
   logic [7:0]  qt_low;
   assign qa_low = qa_ff[23:0];
   assign qt_low = qt_ff[7:0];

   always_comb begin
      rsp.done   = done_ff;
      rsp.volt   = qv_ff[15:0];
      rsp.charge = qc_ff[6:0];
      rsp.amps   = neg_a_ff ? 24'(-qa_low) : qa_low;
      rsp.temp   = neg_t_ff ? 8'(-qt_low) : qt_low;
   end
endmodule
`default_nettype wire

// File: src/psah_history.sv
// ----------------------------------------------------------------------------
// History memory
// Ring storage of samples for all packs, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module psah_history #(
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [86:0]       wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [86:0]            rd_data
);
   logic [86:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: src/psah_state_ram.sv
// ----------------------------------------------------------------------------
// Pack state memory
// Per-pack control words and running sums, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module psah_state_ram #(
   parameter int ADDR_W = 3,
   parameter int DW = 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DW-1:0]     wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [DW-1:0]          rd_data
);
   logic [DW-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: src/pack_sample_averager_history.sv
// ----------------------------------------------------------------------------
// Pack sample averager with ring history
// Per-pack sample history, running sums and periodic averaged records.
// ----------------------------------------------------------------------------
// After reset the block sweeps its pack state memory clear before it takes the
// first transaction. It handles one transaction at a time and accepts the next
// only once it is back in idle. A record that archives waits for the 41-step
// shared divider, and a read returns its samples one at a time through the
// history memory port. An output stall holds an archive or a read in its emit
// state.
`default_nettype none
module pack_sample_averager_history #(
   parameter int PACKS = psah_pkg::PACKS_DEFAULT,
   parameter int HISTORY_DEPTH = psah_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // cmd[1:0], pack[4:2], time_sec[36:5], pack_mv[52:37], current_ma[76:53],
   // charge_pct[83:77], temp_present[84], temp_c[92:85], want_count[99:93]
   input  wire logic [103:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pack_out[2:0], stamp_sec[34:3], volt_mv[50:35], amps_ma[74:51],
   // charge_out[81:75], temp_out[89:82]
   output logic [95:0]       rsp_tdata,
   // kind
   output logic              rsp_tuser,
   output logic              rsp_tlast
);
   localparam int PW = (PACKS > 1) ? $clog2(PACKS) : 1;
   localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FW = $clog2(HISTORY_DEPTH + 1);
   localparam int HAW = PW + HW;
   // state word: due, sum_temp, sum_charge, sum_current, sum_volt, count, fill, wpos
   localparam int SW = 32 + 25 + 24 + 41 + 33 + 17 + FW + HW;

   typedef struct packed {
      logic [31:0] due;
      logic [24:0] st;
      logic [23:0] sc;
      logic [40:0] sa;
      logic [32:0] sv;
      logic [16:0] cnt;
      logic [FW-1:0] fill;
      logic [HW-1:0] wpos;
   } pstate_type;

   logic [15:0] period_ff;
   always_ff @(posedge clock) begin
      if (reset) period_ff <= psah_pkg::PERIOD_RESET;
      else if (csr_wr_en) period_ff <= csr_wr_data;
   end

   psah_pkg::state_type state_ff, state_in;
   logic [PW:0]   sweep_ff;
   logic          sweep_busy;
   assign sweep_busy = !sweep_ff[PW];

   always_ff @(posedge clock) begin
      if (reset) sweep_ff <= '0;
      else if (sweep_busy) sweep_ff <= sweep_ff + 1'b1;
   end

   // Latched transaction.
   logic [1:0]  cmd_ff;
   logic [2:0]  pack_ff;
   logic [31:0] t_ff;
   logic [15:0] mv_ff;
   logic [23:0] ma_ff;
   logic [6:0]  soc_ff;
   logic [7:0]  tc_ff;
   logic [6:0]  want_ff;

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= req_tdata[1:0];
         pack_ff <= req_tdata[4:2];
         t_ff    <= req_tdata[36:5];
         mv_ff   <= req_tdata[52:37];
         ma_ff   <= req_tdata[76:53];
         soc_ff  <= req_tdata[83:77];
         tc_ff   <= req_tdata[84] ? req_tdata[92:85] : 8'd0;
         want_ff <= req_tdata[99:93];
      end
   end

   // State memory, read with the pack of the transaction being accepted.
   logic          st_we;
   logic [PW-1:0] st_waddr;
   logic [PW-1:0] st_raddr;
   pstate_type    st_wdata, st_rdata;
   assign st_raddr = req_fire ? req_tdata[2 +: PW] : pack_ff[PW-1:0];
   psah_state_ram #(.ADDR_W(PW), .DW(SW)) u_state (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   // History memory.
   logic           h_we;
   logic [HW-1:0]  h_rd_idx_ff;
   logic [86:0]    h_rdata;
   psah_history #(.ADDR_W(HAW)) u_hist (
      .clock(clock), .wr_en(h_we),
      .wr_addr({pack_ff[PW-1:0], st_rdata.wpos}),
      .wr_data({tc_ff, soc_ff, ma_ff, mv_ff, t_ff}),
      .rd_addr({pack_ff[PW-1:0], h_rd_idx_ff}),
      .rd_data(h_rdata)
   );

   // Divider.
   psah_pkg::div_req_type dreq;
   psah_pkg::div_rsp_type drsp;
   psah_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   pstate_type upd_ff;
   logic [6:0] left_ff;
   logic       out_full_ff;
   psah_pkg::rsp_type out_ff, out_in;
   logic out_load;

   // Record update computed from the state word.
   pstate_type upd;
   logic       fire;
   logic [31:0] due_now;
   always_comb begin
      upd = st_rdata;
      upd.wpos = (st_rdata.wpos == HW'(HISTORY_DEPTH - 1)) ? '0 : st_rdata.wpos + 1'b1;
      if (st_rdata.fill < FW'(HISTORY_DEPTH)) upd.fill = st_rdata.fill + 1'b1;
      if (st_rdata.cnt < psah_pkg::COUNT_MAX) begin
         upd.cnt = st_rdata.cnt + 1'b1;
         upd.sv  = st_rdata.sv + 33'(mv_ff);
         upd.sa  = st_rdata.sa + 41'(signed'(ma_ff));
         upd.sc  = st_rdata.sc + 24'(soc_ff);
         upd.st  = st_rdata.st + 25'(signed'(tc_ff));
      end
      due_now = (st_rdata.due == 32'd0) ? t_ff + 32'(period_ff) : st_rdata.due;
      upd.due = due_now;
      fire = (t_ff >= due_now);
   end

   logic [FW-1:0] fill_cl;
   logic [6:0]    nread;
   logic [HW:0]   start_sum;
   always_comb begin
      fill_cl = st_rdata.fill;
      nread = (7'(fill_cl) < want_ff) ? 7'(fill_cl) : want_ff;
      start_sum = (HW+1)'(st_rdata.wpos) + (HW+1)'(HISTORY_DEPTH) - (HW+1)'(nread);
   end

   logic pack_ok;
   assign pack_ok = (32'(pack_ff) < 32'(PACKS));

   always_ff @(posedge clock) begin
      if (reset) state_ff <= psah_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) out_full_ff <= 1'b0;
      else if (out_load) out_full_ff <= 1'b1;
      else if (rsp_tready) out_full_ff <= 1'b0;
      if (out_load) out_ff <= out_in;
   end

   logic out_free;
   assign out_free = !out_full_ff || rsp_tready;

   logic [HW-1:0] next_idx;
   assign next_idx = (h_rd_idx_ff == HW'(HISTORY_DEPTH - 1)) ? '0 : h_rd_idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (state_ff == psah_pkg::ST_RD_STATE && psah_pkg::cmd_type'(cmd_ff) == psah_pkg::CMD_READ)
      begin
         h_rd_idx_ff <= (start_sum >= (HW+1)'(HISTORY_DEPTH)) ?
                        HW'(start_sum - (HW+1)'(HISTORY_DEPTH)) : HW'(start_sum);
         left_ff <= nread;
      end else if (state_ff == psah_pkg::ST_HIST_EMIT && out_free) begin
         h_rd_idx_ff <= next_idx;
         left_ff <= left_ff - 1'b1;
      end
      if (state_ff == psah_pkg::ST_RD_STATE) upd_ff <= upd;
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      st_we      = 1'b0;
      st_waddr   = pack_ff[PW-1:0];
      st_wdata   = upd_ff;
      h_we       = 1'b0;
      out_load   = 1'b0;
      out_in     = '0;
      dreq       = '0;
      dreq.divisor     = upd_ff.cnt;
      dreq.sum_volt    = upd_ff.sv;
      dreq.sum_current = upd_ff.sa;
      dreq.sum_charge  = upd_ff.sc;
      dreq.sum_temp    = upd_ff.st;
      if (sweep_busy) begin
         st_we    = 1'b1;
         st_waddr = sweep_ff[PW-1:0];
         st_wdata = '0;
      end
      case (state_ff)
         psah_pkg::ST_IDLE: begin
            req_tready = !sweep_busy;
            if (req_fire) state_in = psah_pkg::ST_RD_STATE;
         end
         psah_pkg::ST_RD_STATE: begin
            state_in = psah_pkg::ST_IDLE;
            if (pack_ok) begin
               case (psah_pkg::cmd_type'(cmd_ff))
                  psah_pkg::CMD_RECORD: begin
                     h_we = 1'b1;
                     if (fire) begin
                        dreq.start = 1'b1;
                        dreq.divisor     = upd.cnt;
                        dreq.sum_volt    = upd.sv;
                        dreq.sum_current = upd.sa;
                        dreq.sum_charge  = upd.sc;
                        dreq.sum_temp    = upd.st;
                        state_in = psah_pkg::ST_DIVIDE;
                     end else begin
                        st_we = 1'b1;
                        st_wdata = upd;
                     end
                  end
                  psah_pkg::CMD_READ: begin
                     if (nread != 7'd0) state_in = psah_pkg::ST_HIST_RD;
                  end
                  psah_pkg::CMD_CLEAR: begin
                     st_we = 1'b1;
                     st_wdata = '0;
                  end
                  default: state_in = psah_pkg::ST_IDLE;
               endcase
            end
         end
         psah_pkg::ST_DIVIDE: begin
            if (drsp.done) state_in = psah_pkg::ST_EMIT_AVG;
         end
         psah_pkg::ST_EMIT_AVG: begin
            if (out_free) begin
               out_load = 1'b1;
               out_in.kind = psah_pkg::KIND_ARCHIVE;
               out_in.pack = pack_ff;
               out_in.stamp = t_ff;
               out_in.volt = drsp.volt;
               out_in.amps = drsp.amps;
               out_in.charge = drsp.charge;
               out_in.temp = drsp.temp;
               out_in.last = 1'b1;
               st_we = 1'b1;
               st_wdata = upd_ff;
               st_wdata.cnt = '0;
               st_wdata.sv = '0;
               st_wdata.sa = '0;
               st_wdata.sc = '0;
               st_wdata.st = '0;
               st_wdata.due = t_ff + 32'(period_ff);
               state_in = psah_pkg::ST_IDLE;
            end
         end
         psah_pkg::ST_HIST_RD: state_in = psah_pkg::ST_HIST_EMIT;
         psah_pkg::ST_HIST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_in.kind = psah_pkg::KIND_HISTORY;
               out_in.pack = pack_ff;
               out_in.stamp = h_rdata[31:0];
               out_in.volt = h_rdata[47:32];
               out_in.amps = h_rdata[71:48];
               out_in.charge = h_rdata[78:72];
               out_in.temp = h_rdata[86:79];
               out_in.last = (left_ff == 7'd1);
               state_in = (left_ff == 7'd1) ? psah_pkg::ST_IDLE : psah_pkg::ST_HIST_RD;
            end
         end
         default: state_in = psah_pkg::ST_IDLE;
      endcase
   end

   assign rsp_tvalid = out_full_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {6'd0, out_ff.temp, out_ff.charge, out_ff.amps, out_ff.volt,
                        out_ff.stamp, out_ff.pack};
endmodule
`default_nettype wire

// File: src/psah_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the ports of the averager for handshake and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none
module psah_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [95:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Result changed while stalled.");
   a_arch_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("Archive record without last.");
   a_no_take: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("Transaction taken during clear sweep.");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Second transaction taken while busy.");
endmodule

bind pack_sample_averager_history psah_checker u_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
);
`default_nettype wire

// File: verif/pack_sample_averager_history_checker.sv
// ----------------------------------------------------------------------------
// Pack sample averager checker
// Watches the request, response and register ports, predicts the averaged
// archive records and history reads of every pack, and compares each response
// transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module pack_sample_averager_history_checker
   import psah_pkg::*;
#(
   parameter int PACKS = 8,
   parameter int HISTORY_DEPTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [15:0]  csr_wr_data,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [103:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [95:0]  rsp_tdata,
   input  wire logic         rsp_tuser,
   input  wire logic         rsp_tlast,
   output int                error_count,
   output int                pending_count
);
   localparam logic [16:0] SAMPLE_LIMIT = COUNT_MAX;

   logic [15:0] period;
   logic [31:0] ring_time [PACKS][HISTORY_DEPTH];
   logic [15:0] ring_volt [PACKS][HISTORY_DEPTH];
   logic [23:0] ring_amps [PACKS][HISTORY_DEPTH];
   logic [6:0]  ring_charge [PACKS][HISTORY_DEPTH];
   logic [7:0]  ring_temp [PACKS][HISTORY_DEPTH];
   int          head [PACKS];
   int          depth_used [PACKS];
   logic [16:0] taken [PACKS];
   longint      acc_volt [PACKS];
   longint      acc_amps [PACKS];
   longint      acc_charge [PACKS];
   longint      acc_temp [PACKS];
   logic [31:0] due [PACKS];
   rsp_type     expected_rsp [$];

   assign pending_count = expected_rsp.size();

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      error_count++;
   endtask

   function automatic void forget_pack(input int p);
      head[p] = 0;
      depth_used[p] = 0;
      taken[p] = '0;
      acc_volt[p] = 0;
      acc_amps[p] = 0;
      acc_charge[p] = 0;
      acc_temp[p] = 0;
      due[p] = '0;
   endfunction

   task automatic predict_request(input logic [103:0] d);
      cmd_type     op;
      int          p, n, idx;
      logic [31:0] t;
      logic [7:0]  tc;
      rsp_type     r;
      op = cmd_type'(d[1:0]);
      p = d[4:2];
      t = d[36:5];
      tc = d[84] ? d[92:85] : 8'd0;
      if (p >= PACKS) return;
      case (op)
         CMD_RECORD: begin
            ring_time[p][head[p]] = t;
            ring_volt[p][head[p]] = d[52:37];
            ring_amps[p][head[p]] = d[76:53];
            ring_charge[p][head[p]] = d[83:77];
            ring_temp[p][head[p]] = tc;
            head[p] = (head[p] + 1) % HISTORY_DEPTH;
            if (depth_used[p] < HISTORY_DEPTH) depth_used[p]++;
            if (taken[p] < SAMPLE_LIMIT) begin
               taken[p]++;
               acc_volt[p] += d[52:37];
               acc_amps[p] += longint'($signed(d[76:53]));
               acc_charge[p] += d[83:77];
               acc_temp[p] += longint'($signed(tc));
            end
            if (due[p] == 0) due[p] = t + 32'(period);
            if (t >= due[p]) begin
               r.kind = KIND_ARCHIVE;
               r.pack = 3'(p);
               r.stamp = t;
               r.volt = 16'(acc_volt[p] / taken[p]);
               r.amps = 24'(acc_amps[p] / longint'(taken[p]));
               r.charge = 7'(acc_charge[p] / taken[p]);
               r.temp = 8'(acc_temp[p] / longint'(taken[p]));
               r.last = 1'b1;
               expected_rsp.push_back(r);
               taken[p] = '0;
               acc_volt[p] = 0;
               acc_amps[p] = 0;
               acc_charge[p] = 0;
               acc_temp[p] = 0;
               due[p] = t + 32'(period);
            end
         end
         CMD_READ: begin
            n = depth_used[p] < int'(d[99:93]) ? depth_used[p] : int'(d[99:93]);
            for (int k = 0; k < n; k++) begin
               idx = (head[p] + HISTORY_DEPTH - n + k) % HISTORY_DEPTH;
               r.kind = KIND_HISTORY;
               r.pack = 3'(p);
               r.stamp = ring_time[p][idx];
               r.volt = ring_volt[p][idx];
               r.amps = ring_amps[p][idx];
               r.charge = ring_charge[p][idx];
               r.temp = ring_temp[p][idx];
               r.last = (k == n - 1);
               expected_rsp.push_back(r);
            end
         end
         CMD_CLEAR: forget_pack(p);
         default: ;
      endcase
   endtask

   task automatic compare_response();
      rsp_type w;
      if (expected_rsp.size() == 0) begin
         report_mismatch("unexpected response", longint'(rsp_tdata[63:0]), 0);
         return;
      end
      w = expected_rsp.pop_front();
      if (rsp_tuser !== w.kind) report_mismatch("kind", rsp_tuser, w.kind);
      if (rsp_tdata[2:0] !== w.pack) report_mismatch("pack", rsp_tdata[2:0], w.pack);
      if (rsp_tdata[34:3] !== w.stamp) report_mismatch("stamp", rsp_tdata[34:3], w.stamp);
      if (rsp_tdata[50:35] !== w.volt) report_mismatch("volt", rsp_tdata[50:35], w.volt);
      if (rsp_tdata[74:51] !== w.amps) report_mismatch("amps", rsp_tdata[74:51], w.amps);
      if (rsp_tdata[81:75] !== w.charge)
         report_mismatch("charge", rsp_tdata[81:75], w.charge);
      if (rsp_tdata[89:82] !== w.temp) report_mismatch("temp", rsp_tdata[89:82], w.temp);
      if (rsp_tlast !== w.last) report_mismatch("last", rsp_tlast, w.last);
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         period <= PERIOD_RESET;
         for (int p = 0; p < PACKS; p++) forget_pack(p);
         expected_rsp.delete();
      end else begin
         if (csr_wr_en) period <= csr_wr_data;
         if (req_tvalid && req_tready) predict_request(req_tdata);
         if (rsp_tvalid && rsp_tready) compare_response();
      end
   end
endmodule
`default_nettype wire

// File: verif/pack_sample_averager_history_test.sv
// ----------------------------------------------------------------------------
// Pack sample averager testbench
// Drives directed and random record, read, clear and ignored transactions in
// bursts across several archive periods, with random and long response stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module pack_sample_averager_history_test;
   import psah_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wr_en = 1'b0;
   logic [15:0]  csr_wr_data = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   int           error_count;
   int           pending_count;
   int           idle_cycles = 0;
   bit           hold_off = 1'b0;
   bit           slow_stalls = 1'b0;
   logic [31:0]  clock_sec [8];

   always #5 clock = ~clock;

   pack_sample_averager_history u_dut (.*);

   pack_sample_averager_history_checker u_checker (.*);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("pack_sample_averager_history_test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else if (slow_stalls) rsp_tready <= ($urandom_range(0, 3) == 0);
      else rsp_tready <= ($urandom_range(0, 4) != 0);
   end

   task automatic send_request(input cmd_type op, input logic [2:0] p, input logic [31:0] t,
                               input logic [15:0] mv, input logic [23:0] ma,
                               input logic [6:0] soc, input logic tp, input logic [7:0] tc,
                               input logic [6:0] want);
      req_tdata <= {4'(0), want, tc, tp, soc, ma, mv, t, p, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic pause_request();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic random_request();
      int          roll;
      logic [2:0]  p;
      roll = $urandom_range(0, 99);
      p = $urandom_range(0, 7);
      clock_sec[p] = clock_sec[p] + $urandom_range(0, 40);
      if (roll < 70)
         send_request(CMD_RECORD, p, clock_sec[p], $urandom, $urandom, $urandom_range(0, 100),
                      $urandom, $urandom, $urandom);
      else if (roll < 90)
         send_request(CMD_READ, p, $urandom, $urandom, $urandom, $urandom_range(0, 100),
                      $urandom, $urandom, $urandom_range(0, 64));
      else if (roll < 95)
         send_request(CMD_CLEAR, p, $urandom, $urandom, $urandom, 0, 0, 0, 0);
      else
         send_request(CMD_NONE, p, $urandom, $urandom, $urandom, 0, 0, 0, $urandom);
   endtask

   task automatic settle_and_write(input logic [15:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(input int count);
      int burst;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            pause_request();
            burst = $urandom_range(1, 12);
         end
         random_request();
         burst--;
      end
   endtask

   initial begin
      foreach (clock_sec[i]) clock_sec[i] = $urandom_range(1, 1000);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every command, the highest pack and wrap of the due time.
      send_request(CMD_RECORD, 0, 32'd10, 16'hFFFF, 24'h7FFFFF, 7'd100, 1'b1, 8'h7F, 0);
      send_request(CMD_RECORD, 0, 32'd20, 16'd0, 24'h800000, 7'd0, 1'b1, 8'h80, 7'h7F);
      send_request(CMD_RECORD, 0, 32'd70, 16'd1, 24'hFFFFFF, 7'd1, 1'b1, 8'hFF, 0);
      send_request(CMD_RECORD, 0, 32'd71, 16'd3, 24'hFFFFFD, 7'd3, 1'b0, 8'h55, 0);
      send_request(CMD_READ, 0, 32'hFFFFFFFF, 16'hFFFF, 24'hFFFFFF, 7'h7F, 1'b1, 8'hFF, 7'd64);
      send_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 7'd2);
      send_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 7'd0);
      send_request(CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 7'd5);
      send_request(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
      send_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 7'd5);
      send_request(CMD_RECORD, 7, 32'hFFFFFFE0, 16'd5, 24'd5, 7'd5, 1'b1, 8'd5, 0);
      send_request(CMD_RECORD, 7, 32'hFFFFFFFF, 16'd6, 24'd6, 7'd6, 1'b0, 8'd0, 0);
      send_request(CMD_RECORD, 7, 32'd3, 16'd7, 24'd7, 7'd7, 1'b1, 8'd7, 0);
      send_request(CMD_READ, 7, 0, 0, 0, 0, 0, 0, 7'd64);
      send_request(CMD_CLEAR, 7, 0, 0, 0, 0, 0, 0, 0);
      settle_and_write(16'd0);
      for (int i = 0; i < 4; i++)
         send_request(CMD_RECORD, 3'(i), 32'(i * 7), $urandom, $urandom, 7'd50, 1'b1,
                      $urandom, 0);
      settle_and_write(16'hFFFF);
      for (int i = 0; i < 40; i++)
         send_request(CMD_RECORD, 1, 32'(100 + i), $urandom, $urandom,
                      $urandom_range(0, 100), $urandom, $urandom, 0);
      send_request(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 7'd64);

      // Long receiver hold-off while the sender keeps offering transactions.
      settle_and_write(16'd1);
      hold_off = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 8; i++)
            send_request(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 7'd64);
      join

      settle_and_write(16'd30);
      random_phase(120);
      slow_stalls = 1'b1;
      settle_and_write(16'd1);
      random_phase(60);
      slow_stalls = 1'b0;
      settle_and_write(16'd200);
      random_phase(100);
      settle_and_write(16'd60);
      random_phase(30);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("pack_sample_averager_history_test passed");
      else $display("pack_sample_averager_history_test failed");
      $finish;
   end
endmodule
`default_nettype wire
